>>> rtl/core/klpd_pkg.sv
package klpd_pkg;

  // Number of key entries held by default.
  localparam int KEY_COUNT_DEFAULT = 256;

  // Reset value of the minimum hold time, in milliseconds.
  localparam logic [15:0] HOLD_FLOOR_RESET = 16'd100;

  // Event kinds carried in the command field.
  localparam logic CMD_DOWN = 1'b0;
  localparam logic CMD_UP   = 1'b1;

  // Per-key status. The fourth code is never written.
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_HELD  = 2'd1,
    ST_FIRED = 2'd2
  } key_status_t;

  // One key event.
  typedef struct packed {
    logic        command;
    logic [7:0]  key_code;
    logic [31:0] tick_ms;
    logic        long_press_mapped;
    logic [15:0] hold_threshold_ms;
  } in_item_t;

  // One event result.
  typedef struct packed {
    logic long_fire;
    logic short_fire;
    logic swallowed;
  } out_item_t;

  // One stored key entry: status and tick of the first down.
  typedef struct packed {
    key_status_t status;
    logic [31:0] press_time;
  } key_entry_t;

endpackage

>>> rtl/core/key_long_press_detector_core.sv
// Tap-or-hold key detector. Each key event (down or up, key code, current millisecond
// tick, mapping flag and hold threshold) yields exactly one result transaction that
// reports a long press, a short press and whether the event is swallowed. The block
// accepts one event per clock cycle unless its input is stalled, and registers its result
// after the lookup stage: the key table is read at the accepting edge, and the status
// update is written back when the lookup stage moves on, together with the output register.
// A stalled result holds the lookup stage, so the input stalls only while both the lookup
// stage and the output register are occupied. Back-to-back events on the same key are served
// by forwarding the last write-back. The key table needs no clearing pass after reset:
// a valid bit per key makes a never-written key read as idle. The floor register
// (hold_floor_ms) must be written only while no event is in flight.
module key_long_press_detector_core
  import klpd_pkg::*;
#(
  parameter int KEY_COUNT = KEY_COUNT_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data
);

  localparam int KEY_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

  // Configuration register.
  logic [15:0] hold_floor_ms;

  // Key table and per-key valid bits.
  key_entry_t           key_mem [KEY_COUNT];
  logic [KEY_COUNT-1:0] entry_valid;

  // Lookup stage.
  logic       s1_valid;
  in_item_t   s1_item;
  key_entry_t rd_entry;

  // Last write-back, kept for forwarding.
  logic             fwd_valid;
  logic [KEY_W-1:0] fwd_key;
  key_entry_t       fwd_entry;

  // Handshake and update signals.
  logic             in_take;
  logic             s1_adv;
  logic             out_free;
  logic [KEY_W-1:0] in_idx;
  logic [KEY_W-1:0] s1_idx;
  logic             s1_active;
  logic             fwd_hit;
  key_entry_t       cur_entry;
  key_status_t      cur_status;
  logic [15:0]      limit_ms;
  logic [31:0]      elapsed_ms;
  key_entry_t       wr_entry;
  out_item_t        result;

  assign out_free = !out_valid || !out_stall;
  assign s1_adv   = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign in_take  = in_valid && !in_stall;
  assign in_idx   = in_data.key_code[KEY_W-1:0];
  assign s1_idx   = s1_item.key_code[KEY_W-1:0];

  // Floor register write.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_floor_ms <= HOLD_FLOOR_RESET;
    end else if (cfg_wr_en) begin
      hold_floor_ms <= cfg_wr_data;
    end
  end

  // Synchronous table read when a transaction is accepted.
  always_ff @(posedge clk) begin
    if (in_take) begin
      rd_entry <= key_mem[in_idx];
      s1_item  <= in_data;
    end
  end

  // Table write-back when the lookup stage moves on with a mapped, in-range key.
  always_ff @(posedge clk) begin
    if (s1_adv && s1_active) begin
      key_mem[s1_idx] <= wr_entry;
    end
  end

  // Control state: stage valid, valid bits and forwarding tag.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      entry_valid <= '0;
      fwd_valid   <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv && s1_active) begin
        entry_valid[s1_idx] <= 1'b1;
        fwd_valid           <= 1'b1;
      end
    end
  end

  // Forwarding payload.
  always_ff @(posedge clk) begin
    if (s1_adv && s1_active) begin
      fwd_key   <= s1_idx;
      fwd_entry <= wr_entry;
    end
  end

  // Status update for the event in the lookup stage.
  always_comb begin
    s1_active  = s1_item.long_press_mapped
                 && ({1'b0, s1_item.key_code} < 9'(KEY_COUNT));
    fwd_hit    = fwd_valid && (fwd_key == s1_idx);
    cur_entry  = fwd_hit ? fwd_entry : rd_entry;
    cur_status = (fwd_hit || entry_valid[s1_idx]) ? cur_entry.status : ST_IDLE;
    limit_ms   = (s1_item.hold_threshold_ms > hold_floor_ms)
                 ? s1_item.hold_threshold_ms : hold_floor_ms;
    elapsed_ms = s1_item.tick_ms - cur_entry.press_time;
    wr_entry   = cur_entry;
    wr_entry.status = cur_status;
    result     = '0;
    if (s1_active) begin
      result.swallowed = 1'b1;
      if (s1_item.command == CMD_DOWN) begin
        case (cur_status)
          ST_IDLE: begin
            wr_entry.status     = ST_HELD;
            wr_entry.press_time = s1_item.tick_ms;
          end
          ST_HELD: begin
            if (elapsed_ms >= {16'd0, limit_ms}) begin
              result.long_fire = 1'b1;
              wr_entry.status  = ST_FIRED;
            end
          end
          default: begin
            // Fired key: repeats are swallowed with no report.
          end
        endcase
      end else begin
        result.short_fire = (cur_status == ST_HELD);
        wr_entry.status   = ST_IDLE;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data <= result;
    end
  end

  // A press is reported either as long or as short, never both.
  a_fire_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.long_fire && out_data.short_fire))
    else $error("long and short press reported together");

  // Any reported press is a swallowed event.
  a_fire_swallowed: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.long_fire || out_data.short_fire)) |-> out_data.swallowed)
    else $error("press reported on an event that was passed on");

  // The input side is held off only by an occupied lookup stage behind a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled without a blocked lookup stage");

  // A stalled result stays in place until taken.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

>>> bench/key_long_press_detector_core_tb.sv
`timescale 1ns / 100ps

module key_long_press_detector_core_tb;
  import klpd_pkg::*;

  localparam int NUM_KEYS     = 256;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int LONG_HOLD    = 300;
  localparam int PHASE_EVENTS = 120;

  // One row of the directed table: the event, and its outcome where it is known by hand.
  typedef struct {
    in_item_t  ev;
    bit        known;
    out_item_t res;
  } event_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;

  // Shadow copy of the key table and the floor register.
  key_status_t key_state [NUM_KEYS];
  logic [31:0] key_down_tick [NUM_KEYS];
  logic [15:0] floor_ms;

  out_item_t   expected_outcomes [$];
  event_row_t  directed_events [$];
  logic [7:0]  key_pool [8];
  logic [31:0] sim_tick;
  int          mismatch_count = 0;
  int          cycle_count = 0;

  // Controls shared between the stimulus and the result side.
  bit          sender_idle = 1'b1;
  bit          receiver_idle = 1'b1;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  int          hold_left = 0;

  key_long_press_detector_core dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Work out the outcome of one key event and update the shadow key table.
  function automatic out_item_t predict_key_event(input in_item_t ev);
    out_item_t   res;
    key_status_t st;
    logic [31:0] limit;
    logic [31:0] elapsed;
    res = '0;
    if (ev.long_press_mapped) begin
      st = key_state[ev.key_code];
      res.swallowed = 1'b1;
      if (ev.command == CMD_DOWN) begin
        case (st)
          ST_IDLE: begin
            key_state[ev.key_code] = ST_HELD;
            key_down_tick[ev.key_code] = ev.tick_ms;
          end
          ST_HELD: begin
            limit = (ev.hold_threshold_ms > floor_ms) ? {16'd0, ev.hold_threshold_ms}
                                                      : {16'd0, floor_ms};
            elapsed = ev.tick_ms - key_down_tick[ev.key_code];
            if (elapsed >= limit) begin
              res.long_fire = 1'b1;
              key_state[ev.key_code] = ST_FIRED;
            end
          end
          default: ;
        endcase
      end else begin
        if (st == ST_HELD) res.short_fire = 1'b1;
        key_state[ev.key_code] = ST_IDLE;
      end
    end
    return res;
  endfunction

  // Random key event: mostly a small pool of keys with a steadily advancing tick.
  function automatic in_item_t random_key_event();
    in_item_t    ev;
    int unsigned sel;
    ev.command = ($urandom_range(99) < 35) ? CMD_UP : CMD_DOWN;
    ev.key_code = ($urandom_range(99) < 85) ? key_pool[$urandom_range(7)] : 8'($urandom);
    sel = $urandom_range(99);
    if (sel < 3) sim_tick = $urandom;
    else if (sel < 13) sim_tick = sim_tick + $urandom_range(70000);
    else sim_tick = sim_tick + $urandom_range(300);
    ev.tick_ms = sim_tick;
    ev.long_press_mapped = ($urandom_range(99) < 90);
    sel = $urandom_range(99);
    if (sel < 10) ev.hold_threshold_ms = '0;
    else if (sel < 20) ev.hold_threshold_ms = 16'($urandom);
    else ev.hold_threshold_ms = 16'($urandom_range(400));
    return ev;
  endfunction

  task automatic add_row(input logic cmd, input logic [7:0] key, input logic [31:0] tick,
                         input logic mapped, input logic [15:0] thr, input bit known,
                         input logic lf, input logic sf, input logic sw);
    event_row_t row;
    row.ev = '{command: cmd, key_code: key, tick_ms: tick, long_press_mapped: mapped,
               hold_threshold_ms: thr};
    row.known = known;
    row.res = '{long_fire: lf, short_fire: sf, swallowed: sw};
    directed_events.push_back(row);
  endtask

  // Offer one transaction and record its expected outcome when it is accepted.
  task automatic send_key_event(input in_item_t ev, input bit known, input out_item_t res);
    out_item_t predicted;
    if (sender_idle) begin
      while ($urandom_range(99) < 36) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data <= ev;
    do @(posedge clk); while (in_stall);
    predicted = predict_key_event(ev);
    expected_outcomes.push_back(known ? res : predicted);
  endtask

  // Stop sending and wait for every outstanding result.
  task automatic drain_events();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_hold_floor(input logic [15:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    floor_ms = value;
  endtask

  task automatic run_random_phase(input int count);
    for (int i = 0; i < 8; i++) key_pool[i] = 8'($urandom);
    for (int i = 0; i < count; i++) send_key_event(random_key_event(), 1'b0, '0);
  endtask

  // Main stimulus.
  initial begin
    for (int i = 0; i < NUM_KEYS; i++) begin
      key_state[i] = ST_IDLE;
      key_down_tick[i] = '0;
    end
    floor_ms = HOLD_FLOOR_RESET;

    // Directed events, run with the floor at its reset value.
    add_row(CMD_UP,   8'd0,   32'd0,          1'b1, 16'd0,      1, 0, 0, 1);
    add_row(CMD_DOWN, 8'd5,   32'd0,          1'b0, 16'd0,      1, 0, 0, 0);
    add_row(CMD_DOWN, 8'd255, 32'd0,          1'b1, 16'd0,      1, 0, 0, 1);
    add_row(CMD_DOWN, 8'd255, 32'd99,         1'b1, 16'd0,      1, 0, 0, 1);
    add_row(CMD_DOWN, 8'd255, 32'd100,        1'b1, 16'd0,      1, 1, 0, 1);
    add_row(CMD_DOWN, 8'd255, 32'd5000,       1'b1, 16'd0,      1, 0, 0, 1);
    add_row(CMD_UP,   8'd255, 32'd5001,       1'b1, 16'd0,      1, 0, 0, 1);
    add_row(CMD_DOWN, 8'd0,   32'hFFFF_FFF0,  1'b1, 16'hFFFF,   1, 0, 0, 1);
    add_row(CMD_DOWN, 8'd0,   32'h0000_FFEE,  1'b1, 16'hFFFF,   0, 0, 0, 0);
    add_row(CMD_DOWN, 8'd0,   32'h0000_FFEF,  1'b1, 16'hFFFF,   0, 0, 0, 0);
    add_row(CMD_DOWN, 8'd7,   32'd1000,       1'b1, 16'd500,    1, 0, 0, 1);
    add_row(CMD_UP,   8'd7,   32'd1100,       1'b0, 16'd500,    1, 0, 0, 0);
    add_row(CMD_DOWN, 8'd7,   32'd1499,       1'b1, 16'd500,    0, 0, 0, 0);
    add_row(CMD_UP,   8'd7,   32'd1500,       1'b1, 16'd500,    1, 0, 1, 1);
    add_row(CMD_DOWN, 8'h80,  32'h1234_5678,  1'b1, 16'h8000,   0, 0, 0, 0);
    add_row(CMD_DOWN, 8'h80,  32'h1234_D677,  1'b1, 16'h8000,   0, 0, 0, 0);
    add_row(CMD_DOWN, 8'h80,  32'h1234_D678,  1'b1, 16'h8000,   0, 0, 0, 0);
    add_row(CMD_UP,   8'h80,  32'h1234_D679,  1'b1, 16'h8000,   0, 0, 0, 0);
    add_row(CMD_UP,   8'd0,   32'h0001_0000,  1'b1, 16'hFFFF,   1, 0, 0, 1);
    add_row(CMD_DOWN, 8'hAA,  32'hFFFF_FFFF,  1'b1, 16'h5555,   0, 0, 0, 0);
    add_row(CMD_UP,   8'hAA,  32'h0000_0010,  1'b1, 16'h5555,   0, 0, 0, 0);
    add_row(CMD_UP,   8'hFF,  32'hFFFF_FFFF,  1'b0, 16'hFFFF,   1, 0, 0, 0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_events[i])
      send_key_event(directed_events[i].ev, directed_events[i].known, directed_events[i].res);

    // Floor at zero, with a tick about to wrap.
    drain_events();
    write_hold_floor(16'h0000);
    sim_tick = 32'hFFFF_FF00;
    run_random_phase(PHASE_EVENTS);

    // Floor at its maximum, with no idling on either side.
    drain_events();
    write_hold_floor(16'hFFFF);
    sender_idle = 1'b0;
    receiver_idle = 1'b0;
    run_random_phase(PHASE_EVENTS);

    // Long receiver hold while the sender keeps offering events back to back.
    drain_events();
    write_hold_floor(16'($urandom_range(50, 400)));
    receiver_idle = 1'b1;
    hold_req <= 1'b1;
    run_random_phase(PHASE_EVENTS);

    // Random floors with idling on both sides.
    drain_events();
    sender_idle = 1'b1;
    write_hold_floor(16'($urandom_range(0, 300)));
    run_random_phase(PHASE_EVENTS);

    drain_events();
    write_hold_floor(16'($urandom));
    run_random_phase(PHASE_EVENTS);

    drain_events();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  // Result side stall: random idling, plus one long hold on request.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end else begin
      out_stall <= receiver_idle && ($urandom_range(99) < 36);
    end
  end

  // Compare each result transaction with the oldest expected outcome.
  always @(posedge clk) begin
    out_item_t exp_res;
    if (!rst && out_valid && !out_stall) begin
      if (expected_outcomes.size() == 0) begin
        $error("Unexpected result transaction: %b", out_data);
        mismatch_count++;
      end else begin
        exp_res = expected_outcomes.pop_front();
        if (out_data.long_fire !== exp_res.long_fire) begin
          $error("long_fire: expected %0b, got %0b", exp_res.long_fire, out_data.long_fire);
          mismatch_count++;
        end
        if (out_data.short_fire !== exp_res.short_fire) begin
          $error("short_fire: expected %0b, got %0b", exp_res.short_fire, out_data.short_fire);
          mismatch_count++;
        end
        if (out_data.swallowed !== exp_res.swallowed) begin
          $error("swallowed: expected %0b, got %0b", exp_res.swallowed, out_data.swallowed);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule

>>> files.f
rtl/core/klpd_pkg.sv
rtl/core/key_long_press_detector_core.sv
bench/key_long_press_detector_core_tb.sv
